FILE: hw/rtl/u8ld_pkg.sv
// u8ld_pkg: shared types and constants for the lenient utf-8 decoder
// request structs, controller state, command and status groups
// no dependencies
`default_nettype none

package u8ld_pkg;

    // field widths
    localparam int unsigned C_BYTE_W    = 8;
    localparam int unsigned C_CODE_W    = 23;
    localparam int unsigned C_MAX_RES   = 4;

    // byte class boundaries
    localparam logic [7:0] C_FOLLOW_MIN = 8'h80;
    localparam logic [7:0] C_LEAD2_BASE = 8'hC0;
    localparam logic [7:0] C_LEAD3_BASE = 8'hE0;
    localparam logic [7:0] C_LEAD4_BASE = 8'hF0;

    // value emitted for a bad sequence in replace mode
    localparam logic [C_CODE_W-1:0] C_REPLACEMENT = 23'h00FFFD;

    // error_mode codes
    localparam logic MODE_REPLACE = 1'b0;
    localparam logic MODE_SKIP    = 1'b1;

    // input request
    typedef struct packed {
        logic [C_BYTE_W-1:0] text_byte;
        logic                final_byte;
    } t_in_item;

    // output request
    typedef struct packed {
        logic [C_CODE_W-1:0] code_value;
        logic                has_value;
        logic                end_of_string;
    } t_out_item;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic pop;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic work_done;
        logic drain_empty;
        logic drain_last;
        logic out_free;
    } t_status;

endpackage : u8ld_pkg

`default_nettype wire

FILE: hw/rtl/u8ld_ctrl.sv
// u8ld_ctrl: sequencer for the lenient utf-8 decoder
// walks load, decode steps and result drain; depends on u8ld_pkg
`default_nettype none

module u8ld_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire u8ld_pkg::t_status i_status,
    output u8ld_pkg::t_cmd         o_cmd
);
    import u8ld_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.work_done) begin
                    n_state = ST_DRAIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_status.drain_empty) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.drain_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule : u8ld_ctrl

`default_nettype wire

FILE: hw/rtl/u8ld_datapath.sv
// u8ld_datapath: byte queue, open-sequence registers, result buffer, output register
// one decode step per cycle on command; depends on u8ld_pkg
`default_nettype none

module u8ld_datapath (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire u8ld_pkg::t_cmd     i_cmd,
    output u8ld_pkg::t_status       o_status,
    input  wire u8ld_pkg::t_in_item i_in_data,
    input  wire                     i_cfg_valid,
    input  wire                     i_cfg_data,
    input  wire                     i_out_stall,
    output logic                    o_out_valid,
    output u8ld_pkg::t_out_item     o_out_data
);
    import u8ld_pkg::*;

    // configuration
    logic                r_mode;

    // open sequence
    logic [7:0]          r_held [4];
    logic [2:0]          r_hc;
    logic [2:0]          r_nl;
    logic                r_bad;
    logic [C_CODE_W-1:0] r_val;

    // pending bytes, head at entry 0
    logic [7:0]          r_q [4];
    logic [2:0]          r_qlen;
    logic                r_final;

    // result buffer and drain
    logic [C_CODE_W-1:0] r_res [4];
    logic [2:0]          r_rcount;
    logic [1:0]          r_didx;
    logic                r_out_valid;
    t_out_item           r_out;

    // step values
    logic                have_byte;
    logic [7:0]          b;
    logic [7:0]          held_w [4];
    logic [2:0]          hc_w;
    logic                bad_w;
    logic [C_CODE_W-1:0] val_w;
    logic [7:0]          qr [4];
    logic [2:0]          qr_len;
    logic [2:0]          k3;
    logic [1:0]          k;
    logic [7:0]          hs [4];
    logic [7:0]          rq [4];
    logic [2:0]          rq_len;
    logic [1:0]          ridx;
    logic [7:0]          lead_base;

    logic [7:0]          n_held [4];
    logic [2:0]          n_hc;
    logic [2:0]          n_nl;
    logic                n_bad;
    logic [C_CODE_W-1:0] n_val;
    logic [7:0]          n_q [4];
    logic [2:0]          n_qlen;
    logic                do_emit;
    logic [C_CODE_W-1:0] emit_val;

    logic [2:0]          drain_total;
    logic [2:0]          didx_next;
    t_out_item           pop_item;

    // incoming byte joins the open sequence
    always_comb begin
        have_byte = (r_qlen != 3'd0);
        b         = r_q[0];
        for (int i = 0; i < 4; i++) begin
            held_w[i] = r_held[i];
        end
        hc_w  = r_hc;
        bad_w = r_bad;
        val_w = r_val;
        if (have_byte && (r_hc != 3'd0)) begin
            held_w[r_hc[1:0]] = b;
            hc_w  = r_hc + 3'd1;
            bad_w = r_bad | (b < C_FOLLOW_MIN);
            val_w = {r_val[C_CODE_W-7:0], 6'b0} + {{(C_CODE_W-7){1'b0}}, b[6:0]};
        end
    end

    // queue after the head is consumed, and the replay queue on failure
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qr[i] = have_byte ? r_q[i+1] : r_q[i];
            hs[i] = held_w[i+1];
        end
        qr[3]  = have_byte ? 8'h00 : r_q[3];
        hs[3]  = 8'h00;
        qr_len = have_byte ? (r_qlen - 3'd1) : r_qlen;
        k3     = hc_w - 3'd1;
        k      = k3[1:0];
        for (int i = 0; i < 4; i++) begin
            ridx = 2'(i) - k;
            rq[i] = (2'(i) < k) ? hs[i] : qr[ridx];
        end
        rq_len = k3 + qr_len;
    end

    // lead byte base
    always_comb begin
        priority if (b >= C_LEAD4_BASE) begin
            lead_base = C_LEAD4_BASE;
        end else if (b >= C_LEAD3_BASE) begin
            lead_base = C_LEAD3_BASE;
        end else begin
            lead_base = C_LEAD2_BASE;
        end
    end

    // one decode step
    always_comb begin
        logic do_fail;
        do_fail  = 1'b0;
        do_emit  = 1'b0;
        emit_val = '0;
        for (int i = 0; i < 4; i++) begin
            n_held[i] = held_w[i];
            n_q[i]    = qr[i];
        end
        n_hc   = hc_w;
        n_nl   = r_nl;
        n_bad  = bad_w;
        n_val  = val_w;
        n_qlen = qr_len;
        if (have_byte) begin
            if (r_hc == 3'd0) begin
                priority if (b < C_FOLLOW_MIN) begin
                    do_emit  = 1'b1;
                    emit_val = {{(C_CODE_W-8){1'b0}}, b};
                end else if (b < C_LEAD2_BASE) begin
                    do_emit  = (r_mode == MODE_REPLACE);
                    emit_val = C_REPLACEMENT;
                end else begin
                    n_held[0] = b;
                    n_hc      = 3'd1;
                    n_bad     = 1'b0;
                    n_val     = {{(C_CODE_W-8){1'b0}}, b - lead_base};
                    priority if (b >= C_LEAD4_BASE) begin
                        n_nl = 3'd4;
                    end else if (b >= C_LEAD3_BASE) begin
                        n_nl = 3'd3;
                    end else begin
                        n_nl = 3'd2;
                    end
                end
            end else if (bad_w) begin
                do_fail = (r_mode == MODE_REPLACE) || (hc_w >= r_nl);
            end else if (hc_w >= r_nl) begin
                do_emit  = 1'b1;
                emit_val = val_w;
                n_hc     = 3'd0;
                n_nl     = 3'd0;
            end
        end else begin
            // string ended with a sequence still open
            do_fail = 1'b1;
        end
        if (do_fail) begin
            n_hc = 3'd0;
            n_nl = 3'd0;
            if (r_mode == MODE_REPLACE) begin
                do_emit  = 1'b1;
                emit_val = C_REPLACEMENT;
                for (int i = 0; i < 4; i++) begin
                    n_q[i] = rq[i];
                end
                n_qlen = rq_len;
            end
        end
    end

    // drain bookkeeping
    always_comb begin
        drain_total = ((r_rcount == 3'd0) && r_final) ? 3'd1 : r_rcount;
        didx_next   = {1'b0, r_didx} + 3'd1;
        if (r_rcount == 3'd0) begin
            pop_item.code_value    = '0;
            pop_item.has_value     = 1'b0;
            pop_item.end_of_string = 1'b1;
        end else begin
            pop_item.code_value    = r_res[r_didx];
            pop_item.has_value     = 1'b1;
            pop_item.end_of_string = r_final && (didx_next == drain_total);
        end
    end

    // status to the controller
    always_comb begin
        o_status.work_done   = !have_byte && !(r_final && (r_hc != 3'd0));
        o_status.drain_empty = (drain_total == 3'd0);
        o_status.drain_last  = (didx_next == drain_total);
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_REPLACE;
            r_hc        <= 3'd0;
            r_nl        <= 3'd0;
            r_bad       <= 1'b0;
            r_qlen      <= 3'd0;
            r_final     <= 1'b0;
            r_rcount    <= 3'd0;
            r_didx      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_qlen   <= 3'd1;
                r_final  <= i_in_data.final_byte;
                r_rcount <= 3'd0;
                r_didx   <= 2'd0;
            end
            if (i_cmd.step) begin
                r_hc   <= n_hc;
                r_nl   <= n_nl;
                r_bad  <= n_bad;
                r_qlen <= n_qlen;
                if (do_emit && (r_rcount < 3'(C_MAX_RES))) begin
                    r_rcount <= r_rcount + 3'd1;
                end
            end
            if (i_cmd.pop) begin
                r_didx      <= r_didx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q[0] <= i_in_data.text_byte;
        end
        if (i_cmd.step) begin
            for (int i = 0; i < 4; i++) begin
                r_held[i] <= n_held[i];
                r_q[i]    <= n_q[i];
            end
            r_val <= n_val;
            if (do_emit && (r_rcount < 3'(C_MAX_RES))) begin
                r_res[r_rcount[1:0]] <= emit_val;
            end
        end
        if (i_cmd.pop) begin
            r_out <= pop_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule : u8ld_datapath

`default_nettype wire

FILE: hw/rtl/utf8_lenient_decoder_unit.sv
// order: accept the byte, then one decode step for each byte fed (replayed bytes again,
// plus one for closing a cut-off sequence), a finishing check, then one pop per result
// flow: one byte at a time; a new byte is taken only after the last one's results drain
// reset: synchronous active low, clears mode, open sequence, queue and output valid
`default_nettype none

module utf8_lenient_decoder_unit (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire u8ld_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output u8ld_pkg::t_out_item     o_out_data,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire                     i_cfg_data
);
    import u8ld_pkg::*;

    t_cmd    cmd;
    t_status status;

    // mode register takes writes at any time
    assign o_cfg_ready = 1'b1;

    // sequencer
    u8ld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // decode datapath
    u8ld_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> !(o_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // a loaded result shows up next cycle
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |=> o_out_valid)
        else $error("popped result not presented");

    // a new request is loaded only on an accepted input
    a_load_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (i_in_valid && !o_in_stall))
        else $error("load without accepted request");

    // decode, load and drain never overlap
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.step, cmd.pop}))
        else $error("overlapping datapath commands");
`endif

endmodule : utf8_lenient_decoder_unit

`default_nettype wire

FILE: tb/utf8_lenient_decoder_unit_checker.sv
`timescale 1ns / 100ps
// utf8_lenient_decoder_unit_checker: watches the byte, result and mode channels,
// predicts the decoded results of each byte request and compares them in order
// depends on u8ld_pkg for the request structs and the mode and byte class constants

module utf8_lenient_decoder_unit_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  u8ld_pkg::t_in_item  i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  u8ld_pkg::t_out_item i_out_data,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_ready,
    input  wire                 i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    import u8ld_pkg::*;

    // predictor state
    logic        dec_mode;
    logic [7:0]  seq_bytes [4];
    int          seq_count;
    int          seq_len;
    logic [7:0]  replay_q [$];
    t_out_item   step_results [$];
    t_out_item   expected_codes [$];
    int          error_count = 0;

    task report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // one decoded value, at most four per byte request
    function void emit_code(input logic [31:0] v);
        t_out_item r;
        if (step_results.size() < C_MAX_RES) begin
            r.code_value    = v[C_CODE_W-1:0];
            r.has_value     = 1'b1;
            r.end_of_string = 1'b0;
            step_results.push_back(r);
        end
    endfunction

    // give up on the open sequence; replace mode replays the bytes behind the lead
    function void drop_sequence();
        int i;
        if (dec_mode == MODE_REPLACE) begin
            emit_code({9'd0, C_REPLACEMENT});
            for (i = seq_count - 1; i >= 1; i--)
                replay_q.push_front(seq_bytes[i]);
        end
        seq_count = 0;
        seq_len   = 0;
    endfunction

    function logic bad_follow();
        int i;
        for (i = 1; i < seq_count; i++)
            if (seq_bytes[i] < C_FOLLOW_MIN) return 1'b1;
        return 1'b0;
    endfunction

    // lenient value: lead minus base, then six bits per follow byte
    function logic [31:0] seq_value();
        logic [31:0] v;
        logic [31:0] base;
        int          i;
        base = (seq_len == 4) ? {24'd0, C_LEAD4_BASE} :
               (seq_len == 3) ? {24'd0, C_LEAD3_BASE} : {24'd0, C_LEAD2_BASE};
        v = {24'd0, seq_bytes[0]} - base;
        for (i = 1; i < seq_len; i++)
            v = v * 32'd64 + ({24'd0, seq_bytes[i]} - 32'd128);
        return v;
    endfunction

    function void feed_byte(input logic [7:0] b);
        if (seq_count == 0) begin
            if (b < C_FOLLOW_MIN) begin
                emit_code({24'd0, b});
            end else if (b < C_LEAD2_BASE) begin
                // stray follow byte
                if (dec_mode == MODE_REPLACE) emit_code({9'd0, C_REPLACEMENT});
            end else begin
                seq_bytes[0] = b;
                seq_count    = 1;
                seq_len      = (b >= C_LEAD4_BASE) ? 4 : (b >= C_LEAD3_BASE) ? 3 : 2;
            end
        end else begin
            if (seq_count < 4) begin
                seq_bytes[seq_count] = b;
                seq_count++;
            end
            if (bad_follow()) begin
                if (dec_mode == MODE_REPLACE || seq_count >= seq_len) drop_sequence();
            end else if (seq_count >= seq_len) begin
                emit_code(seq_value());
                seq_count = 0;
                seq_len   = 0;
            end
        end
    endfunction

    // all results caused by one byte request, end mark on the last
    function void decode_request(input t_in_item req);
        t_out_item r;
        step_results.delete();
        replay_q.delete();
        replay_q.push_back(req.text_byte);
        while (replay_q.size() > 0 || (req.final_byte && seq_count > 0)) begin
            if (replay_q.size() > 0) feed_byte(replay_q.pop_front());
            else drop_sequence();
        end
        if (req.final_byte) begin
            if (step_results.size() == 0) begin
                // bare end marker
                r.code_value    = '0;
                r.has_value     = 1'b0;
                r.end_of_string = 1'b1;
            end else begin
                r = step_results.pop_back();
                r.end_of_string = 1'b1;
            end
            step_results.push_back(r);
        end
        foreach (step_results[i]) expected_codes.push_back(step_results[i]);
    endfunction

    // channel monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            dec_mode  = MODE_REPLACE;
            seq_count = 0;
            seq_len   = 0;
            expected_codes.delete();
        end else begin
            // result request against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0b/%0b with nothing expected",
                        i_out_data.code_value, i_out_data.has_value,
                        i_out_data.end_of_string));
                end else begin
                    want = expected_codes.pop_front();
                    if (i_out_data.code_value !== want.code_value)
                        report_mismatch($sformatf("code_value %0d, expected %0d",
                            i_out_data.code_value, want.code_value));
                    if (i_out_data.has_value !== want.has_value)
                        report_mismatch($sformatf("has_value %0b, expected %0b",
                            i_out_data.has_value, want.has_value));
                    if (i_out_data.end_of_string !== want.end_of_string)
                        report_mismatch($sformatf("end_of_string %0b, expected %0b",
                            i_out_data.end_of_string, want.end_of_string));
                end
            end
            // mode write
            if (i_cfg_valid && i_cfg_ready) dec_mode = i_cfg_data;
            // byte request
            if (i_in_valid && !i_in_stall) decode_request(i_in_data);
        end
        o_pending <= expected_codes.size();
        o_errors  <= error_count;
    end

endmodule

FILE: tb/utf8_lenient_decoder_unit_tb.sv
`timescale 1ns / 100ps
// utf8_lenient_decoder_unit_tb: drives byte strings, mode writes and result stalls
// into the decoder and gives the verdict from the checker's counts
// depends on u8ld_pkg, utf8_lenient_decoder_unit and utf8_lenient_decoder_unit_checker

module utf8_lenient_decoder_unit_tb;
    import u8ld_pkg::*;

    typedef logic [7:0] t_text [$];

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_data  = 1'b0;

    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      cfg_ready;
    int        errors;
    int        pending;

    int        bytes_sent = 0;
    logic      tx_calm    = 1'b0;
    logic      rx_calm    = 1'b0;
    t_text     text_q;

    utf8_lenient_decoder_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    utf8_lenient_decoder_unit_checker decode_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("utf8_lenient_decoder_unit verification failed");
        $finish;
    end

    // mostly short gaps, a few long ones, none in calm stretches
    function int gap_len(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side stalls
    initial begin
        int n;
        forever begin
            n = gap_len(rx_calm);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // one byte request, returns at the edge that takes it
    task send_byte(input logic [7:0] b, input logic fin);
        int n;
        n = gap_len(tx_calm);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{text_byte: b, final_byte: fin};
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task send_text(input t_text txt, input logic fin);
        int i;
        for (i = 0; i < txt.size(); i++)
            send_byte(txt[i], fin && (i == txt.size() - 1));
    endtask

    // mode write once every result is out and the last byte has settled
    task write_mode(input logic m);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function logic [7:0] lead_for(input int n);
        if (n == 2) return 8'($urandom_range(8'hC0, 8'hDF));
        if (n == 3) return 8'($urandom_range(8'hE0, 8'hEF));
        return 8'($urandom_range(8'hF0, 8'hFF));
    endfunction

    // append one random character: mostly well formed, some noise, some broken
    task add_char();
        int kind;
        int n;
        int m;
        int i;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            text_q.push_back(8'($urandom_range(0, 127)));
        end else if (kind < 66) begin
            n = (kind < 42) ? 2 : (kind < 54) ? 3 : 4;
            text_q.push_back(lead_for(n));
            for (i = 1; i < n; i++) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (kind < 80) begin
            text_q.push_back(8'($urandom));
        end else begin
            // follow byte below 0x80 partway into a sequence
            n = $urandom_range(2, 4);
            m = $urandom_range(0, n - 2);
            text_q.push_back(lead_for(n));
            for (i = 0; i < m; i++) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            text_q.push_back(8'($urandom_range(0, 8'h7F)));
        end
    endtask

    // stimulus
    initial begin
        int   phase;
        int   chars;
        logic fin;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: replace mode
        write_mode(MODE_REPLACE);
        send_text('{8'h00, 8'h7F}, 1'b1);
        send_text('{8'hDF, 8'hBF}, 1'b1);
        send_text('{8'hE0, 8'h80, 8'h80, 8'hFF, 8'hBF, 8'hBF, 8'hBF}, 1'b1);
        send_text('{8'h80}, 1'b1);
        send_text('{8'hE2, 8'h82}, 1'b1);
        send_text('{8'hF0, 8'h41}, 1'b1);

        // directed: skip mode, bare end markers, then mode change inside a sequence
        write_mode(MODE_SKIP);
        send_text('{8'hF0, 8'h90, 8'h41, 8'h80, 8'hBF}, 1'b1);
        send_text('{8'hC3}, 1'b1);
        send_text('{8'hF0, 8'h41}, 1'b0);
        write_mode(MODE_REPLACE);
        send_text('{8'h80, 8'h42}, 1'b1);

        // random strings in alternating modes; open sequences may cross a mode write
        for (phase = 0; phase < 4; phase++) begin
            write_mode(phase[0] ? MODE_SKIP : MODE_REPLACE);
            while (bytes_sent < 26 + (phase + 1) * 72) begin
                tx_calm = ($urandom_range(0, 5) == 0);
                rx_calm = ($urandom_range(0, 5) == 0);
                text_q.delete();
                chars = $urandom_range(1, 6);
                repeat (chars) add_char();
                fin = ($urandom_range(0, 9) != 0);
                send_text(text_q, fin);
            end
        end

        // drain
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("utf8_lenient_decoder_unit verification clean");
        end else begin
            $display("utf8_lenient_decoder_unit verification failed");
        end
        $finish;
    end

endmodule
